>>> rtl/hard_disk_event_collision_search_assert.svh
`ifndef HARD_DISK_EVENT_COLLISION_SEARCH_ASSERT_SVH
`define HARD_DISK_EVENT_COLLISION_SEARCH_ASSERT_SVH
// same-cycle implication, held off during reset
`define HDECS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("label failed");
// next-cycle implication, checked through reset
`define HDECS_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("label failed");
`endif

>>> rtl/hdecs_pkg.sv
package hdecs_pkg;
    localparam int COORD_FRAC_BITS_DEF = 24;
    localparam int ID_BITS_DEF         = 16;
    localparam int LEN_BITS            = 31;
    localparam int QUEUE_DEPTH         = 4;
    localparam logic [23:0] TWO_SIGMA_RESET = 24'd248366;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;
endpackage

>>> rtl/hdecs_front.sv
module hdecs_front
    import hdecs_pkg::*;
#(
    parameter int F  = COORD_FRAC_BITS_DEF,
    parameter int IW = ID_BITS_DEF,
    parameter int JW = 4*F + IW + LEN_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [F-1:0]      i_cfg_wdata,
    input  logic [F-1:0]      i_ax,
    input  logic [F-1:0]      i_ay,
    input  logic [IW-1:0]     i_aid,
    input  logic              i_along_x,
    input  logic [LEN_BITS-1:0] i_rem,
    input  logic [F-1:0]      i_cx,
    input  logic [F-1:0]      i_cy,
    input  logic [IW-1:0]     i_cid,
    input  logic              i_last,
    output logic [JW-1:0]     o_job
);
    logic [F-1:0]   r_two_sigma;
    logic [F-1:0]   pa, pc, qa, qc, g, gap;
    logic [F:0]     h;
    logic [2*F-1:0] ts2, gap2, sq;
    logic           cand_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_sigma <= F'(TWO_SIGMA_RESET);
        end else if (i_cfg_we) begin
            r_two_sigma <= i_cfg_wdata;
        end
    end

    always_comb begin
        pa = i_along_x ? i_ay : i_ax;
        pc = i_along_x ? i_cy : i_cx;
        qa = i_along_x ? i_ax : i_ay;
        qc = i_along_x ? i_cx : i_cy;
        g  = pc - pa;
        h  = {1'b1, {F{1'b0}}} - {1'b0, g};
        // h only beats g when g is past one half, so it fits in F bits then
        gap = ({1'b0, g} < h) ? g : h[F-1:0];
        ts2  = r_two_sigma * r_two_sigma;
        gap2 = gap * gap;
        sq   = ts2 - gap2;
        cand_ok = (i_cid != i_aid) && (gap <= r_two_sigma);
    end

    assign o_job = {sq, qa, qc, i_cid, i_rem, cand_ok, i_last};
endmodule

>>> rtl/hdecs_queue.sv
module hdecs_queue
    import hdecs_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_queue_stat  o_stat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule

>>> rtl/hdecs_back.sv
module hdecs_back
    import hdecs_pkg::*;
#(
    parameter int F  = COORD_FRAC_BITS_DEF,
    parameter int IW = ID_BITS_DEF,
    parameter int JW = 4*F + IW + LEN_BITS + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [JW-1:0]       i_job,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [LEN_BITS-1:0] o_len,
    output logic [IW-1:0]       o_id,
    output logic                o_hit
);
    localparam int CNW = (F > 1) ? $clog2(F) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROOT = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNW-1:0]      r_cnt;
    logic [2*F-1:0]      r_rad;
    logic [F+1:0]        r_part;
    logic [F-1:0]        r_root;
    logic [F-1:0]        r_qa, r_qc;
    logic [IW-1:0]       r_cid;
    logic [LEN_BITS-1:0] r_rem;
    logic                r_ok, r_last;
    logic [LEN_BITS-1:0] r_best;
    logic [IW-1:0]       r_best_id;
    logic                r_found, r_in_group;

    logic [F+2:0]        shifted, trial, diff;
    logic [F-1:0]        fwd;
    logic [LEN_BITS-1:0] base, fwd_ext;
    logic                win, out_busy, fin_go;

    always_comb begin
        // remainder stays below 2^(F+1), so its top bit is always clear
        shifted = {r_part[F:0], r_rad[2*F-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        diff   = shifted - trial;
        fwd    = r_qc - r_qa - r_root;
        fwd_ext = LEN_BITS'(fwd);
        base   = r_in_group ? r_best : r_rem;
        win    = r_ok && (fwd_ext < base);
        out_busy = o_valid && !i_ready;
        fin_go = !(r_last && out_busy);
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty) n_state = S_ROOT;
            S_ROOT:  if (r_cnt == CNW'(F - 1)) n_state = S_FIN;
            S_FIN:   if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_group <= 1'b0;
            r_best     <= '0;
            r_best_id  <= '0;
            r_found    <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && fin_go && r_last) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (r_state == S_FIN && fin_go) begin
                r_best     <= win ? fwd_ext : base;
                r_best_id  <= win ? r_cid : (r_in_group ? r_best_id : '0);
                r_found    <= win || (r_in_group && r_found);
                r_in_group <= !r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_rad, r_qa, r_qc, r_cid, r_rem, r_ok, r_last} <= i_job;
            r_part <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_state == S_ROOT) begin
            // one root bit per cycle
            if (!diff[F+2]) begin
                r_part <= diff[F+1:0];
                r_root <= {r_root[F-2:0], 1'b1};
            end else begin
                r_part <= shifted[F+1:0];
                r_root <= {r_root[F-2:0], 1'b0};
            end
            r_rad <= {r_rad[2*F-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_FIN && fin_go && r_last) begin
            o_len <= win ? fwd_ext : base;
            o_hit <= win || (r_in_group && r_found);
            o_id  <= win ? r_cid : ((r_in_group && r_found) ? r_best_id : '0);
        end
    end
endmodule

>>> rtl/hard_disk_event_collision_search.sv
// chan  dir  tdata (low bit up)                              tuser         tlast
// s     in   active_x, active_y, active_id, remaining,       move_along_x  last_cand
//            cand_x, cand_y, cand_id
// m     out  event_length, next_id                           hit           -
// cfg   in   two_sigma on i_cfg_wdata when i_cfg_we
// Each candidate passes through the back end's idle, root and finish states, paced by
// the bit-serial square root (one root bit per cycle); the front takes a beat a cycle
// while the queue has room, so up to QUEUE_DEPTH beats buffer ahead.
// Reset is synchronous: queue empties, no group is open, two_sigma reloads.
// A last candidate waits in the back end while the previous result is unread.
`include "hard_disk_event_collision_search_assert.svh"
module hard_disk_event_collision_search
    import hdecs_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ID_BITS         = ID_BITS_DEF,
    localparam int F   = COORD_FRAC_BITS,
    localparam int INB = 4*F + 2*ID_BITS + LEN_BITS,
    localparam int INW = ((INB + 7) / 8) * 8,
    localparam int OUB = LEN_BITS + ID_BITS,
    localparam int OUW = ((OUB + 7) / 8) * 8,
    localparam int JW  = 4*F + ID_BITS + LEN_BITS + 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [F-1:0]   i_cfg_wdata,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    // active_x, active_y, active_id, remaining, cand_x, cand_y, cand_id
    input  logic [INW-1:0] i_s_tdata,
    // move_along_x
    input  logic           i_s_tuser,
    input  logic           i_s_tlast,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    // event_length, next_id
    output logic [OUW-1:0] o_m_tdata,
    // hit
    output logic           o_m_tuser
);
    logic [JW-1:0]       job_in, job_out;
    t_queue_stat         qstat;
    logic                pop, push;
    logic [LEN_BITS-1:0] len;
    logic [ID_BITS-1:0]  nid;

    assign o_s_tready = !qstat.full;
    assign push = i_s_tvalid && o_s_tready;

    hdecs_front #(.F(F), .IW(ID_BITS), .JW(JW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ax        (i_s_tdata[F-1:0]),
        .i_ay        (i_s_tdata[2*F-1:F]),
        .i_aid       (i_s_tdata[2*F+ID_BITS-1:2*F]),
        .i_along_x   (i_s_tuser),
        .i_rem       (i_s_tdata[2*F+ID_BITS+LEN_BITS-1:2*F+ID_BITS]),
        .i_cx        (i_s_tdata[3*F+ID_BITS+LEN_BITS-1:2*F+ID_BITS+LEN_BITS]),
        .i_cy        (i_s_tdata[4*F+ID_BITS+LEN_BITS-1:3*F+ID_BITS+LEN_BITS]),
        .i_cid       (i_s_tdata[INB-1:4*F+ID_BITS+LEN_BITS]),
        .i_last      (i_s_tlast),
        .o_job       (job_in)
    );

    hdecs_queue #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (qstat)
    );

    hdecs_back #(.F(F), .IW(ID_BITS), .JW(JW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (qstat.empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_len   (len),
        .o_id    (nid),
        .o_hit   (o_m_tuser)
    );

    assign o_m_tdata = {{(OUW-OUB){1'b0}}, nid, len};

    `HDECS_ASSERT_NOW(a_queue_stat, i_clk, i_rst_n, qstat.full, !qstat.empty)
    `HDECS_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, pop, !qstat.empty)
    `HDECS_ASSERT_NOW(a_miss_id_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, nid == '0)
    `HDECS_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_m_tvalid && qstat.empty)
endmodule

>>> tb/sv/hard_disk_event_collision_search_test.sv
`timescale 1ns / 100ps
module hard_disk_event_collision_search_test;
    import hdecs_pkg::*;

    localparam int F   = COORD_FRAC_BITS_DEF;
    localparam int IDB = ID_BITS_DEF;
    localparam int INB = 4*F + 2*IDB + LEN_BITS;
    localparam int INW = ((INB + 7) / 8) * 8;
    localparam int OUB = LEN_BITS + IDB;
    localparam int OUW = ((OUB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 4 * (F + 2) * QUEUE_DEPTH;

    typedef struct packed {
        logic [F-1:0]        ax;
        logic [F-1:0]        ay;
        logic [IDB-1:0]      aid;
        logic                along_x;
        logic [LEN_BITS-1:0] rem;
        logic [F-1:0]        cx;
        logic [F-1:0]        cy;
        logic [IDB-1:0]      cid;
        logic                last;
    } cand_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic [IDB-1:0]      id;
        logic                hit;
    } event_t;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [F-1:0] i_cfg_wdata = '0;
    logic i_s_tvalid = 0, o_s_tready;
    logic [INW-1:0] i_s_tdata = '0;
    logic i_s_tuser = 0, i_s_tlast = 0;
    logic o_m_tvalid, i_m_tready = 0;
    logic [OUW-1:0] o_m_tdata;
    logic o_m_tuser;

    hard_disk_event_collision_search dut (.*);

    initial forever #10 i_clk = ~i_clk;

    cand_t  pending[$];
    event_t events_due[$];
    logic [23:0] sigma_m = TWO_SIGMA_RESET;
    logic [LEN_BITS-1:0] best_len_m = '0;
    logic [IDB-1:0] best_id_m = '0;
    logic found_m = 0, open_m = 0;
    int errors = 0;
    int cycles = 0;
    int burst_left = 0, gap_left = 0;
    bit hold_tx = 0;

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit path_dist(logic [F-1:0] pa, pc, qa, qc,
                                     output logic [F-1:0] d);
        logic [63:0] g, h, gap, para;
        g = {40'd0, F'(pc - pa)};
        h = (64'd1 << F) - g;
        gap = (g < h) ? g : h;
        d = '0;
        if (gap > {40'd0, sigma_m}) return 0;
        para = root64({40'd0, sigma_m} * {40'd0, sigma_m} - gap * gap);
        d = F'(qc - qa - para[F-1:0]);
        return 1;
    endfunction

    task automatic predict_collision(cand_t c);
        logic [F-1:0] d;
        bit h;
        event_t ev;
        if (!open_m) begin
            best_len_m = c.rem;
            best_id_m = '0;
            found_m = 0;
        end
        if (c.cid != c.aid) begin
            if (c.along_x) h = path_dist(c.ay, c.cy, c.ax, c.cx, d);
            else h = path_dist(c.ax, c.cx, c.ay, c.cy, d);
            if (h && {7'd0, d} < best_len_m) begin
                best_len_m = {7'd0, d};
                best_id_m = c.cid;
                found_m = 1;
            end
        end
        if (c.last) begin
            open_m = 0;
            ev = '{best_len_m, found_m ? best_id_m : '0, found_m};
            events_due = {events_due, ev};
        end else begin
            open_m = 1;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (i_s_tvalid) predict_collision(pending.pop_front());
                if (pending.size() != 0 && !hold_tx && gap_left == 0) begin
                    i_s_tvalid <= 1;
                    i_s_tdata <= INW'({pending[0].cid, pending[0].cy, pending[0].cx,
                        pending[0].rem, pending[0].aid, pending[0].ay, pending[0].ax});
                    i_s_tuser <= pending[0].along_x;
                    i_s_tlast <= pending[0].last;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                    end else if (burst_left == 1) begin
                        burst_left <= 0;
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 0;
                    if (gap_left != 0) gap_left <= gap_left - 1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (events_due.size() == 0) begin
                    $display("%0t: unexpected result len=%h id=%h hit=%b", $realtime,
                        o_m_tdata[LEN_BITS-1:0], o_m_tdata[OUB-1:LEN_BITS], o_m_tuser);
                    errors <= errors + 1;
                end else begin
                    event_t e;
                    e = events_due.pop_front();
                    if (o_m_tdata[LEN_BITS-1:0] !== e.len || o_m_tdata[OUB-1:LEN_BITS] !== e.id
                            || o_m_tuser !== e.hit) begin
                        $display("%0t: mismatch expected len=%h id=%h hit=%b actual len=%h id=%h hit=%b",
                            $realtime, e.len, e.id, e.hit, o_m_tdata[LEN_BITS-1:0],
                            o_m_tdata[OUB-1:LEN_BITS], o_m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
            // stall pattern: long stretches ready nine times in ten, alternating with stretches ready one time in three
            i_m_tready <= (cycles % 97 < 60) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // random link with content steered near the active disk
    task automatic queue_link(int n, int self_pct);
        cand_t c;
        logic [F-1:0] ax, ay;
        logic [IDB-1:0] aid;
        logic ax_dir;
        ax = F'($urandom); ay = F'($urandom); aid = IDB'($urandom);
        ax_dir = 1'($urandom);
        for (int i = 0; i < n; i++) begin
            c.ax = ax; c.ay = ay; c.aid = aid; c.along_x = ax_dir;
            c.rem = ($urandom_range(0, 7) == 0) ? LEN_BITS'($urandom)
                                                : LEN_BITS'($urandom_range(0, 1 << 25));
            if ($urandom_range(0, 3) == 0) begin
                c.cx = F'($urandom); c.cy = F'($urandom);
            end else begin
                c.cx = ax + F'($urandom_range(0, 600000)) - F'(300000);
                c.cy = ay + F'($urandom_range(0, 600000)) - F'(300000);
            end
            c.cid = ($urandom_range(0, 99) < self_pct) ? aid : IDB'($urandom);
            c.last = (i == n - 1);
            pending = {pending, c};
        end
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || i_s_tvalid || events_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sigma(logic [F-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sigma_m = v;
    endtask

    initial begin
        cand_t c;
        int total;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, self candidate, both axes, wrap
        c = '{'0, '0, '0, 1'b1, '0, '0, '0, 16'd1, 1'b1};
        pending = {pending, c};
        c = '{'1, '1, '1, 1'b0, '1, '1, '1, '1, 1'b1};
        pending = {pending, c};
        c = '{'0, '0, 16'd5, 1'b1, 31'h40000000, F'(100), '1, 16'd7, 1'b0};
        pending = {pending, c};
        c = '{'1, '1, 16'd5, 1'b0, '0, F'(1000), F'(50), 16'd5, 1'b0};
        pending = {pending, c};
        c = '{'1, '1, 16'd5, 1'b0, '0, F'(2), F'(20), 16'd9, 1'b1};
        pending = {pending, c};
        c = '{24'h800000, 24'h800000, 16'd3, 1'b1, 31'h1000000, 24'h7FFF00, 24'h800010,
              16'hFFFF, 1'b1};
        pending = {pending, c};
        queue_link(6, 30);
        wait_idle();

        set_sigma('0);
        queue_link(5, 10);
        queue_link(1, 0);
        wait_idle();
        set_sigma(24'h800000);
        queue_link(8, 10);
        wait_idle();
        set_sigma('1);
        queue_link(8, 10);
        wait_idle();
        set_sigma(TWO_SIGMA_RESET);

        total = 0;
        while (total < 1850) begin
            int n;
            if (total > 0 && total % 400 < 10) begin
                wait_idle();
                hold_tx = 1;
                case ($urandom_range(0, 3))
                    0: set_sigma(F'($urandom_range(0, 24'h800000)));
                    1: set_sigma(F'($urandom_range(100000, 400000)));
                    2: set_sigma(F'($urandom));
                    default: set_sigma(TWO_SIGMA_RESET);
                endcase
                hold_tx = 0;
            end
            n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            queue_link(n, 10);
            total += n;
            while (pending.size() > 40) @(posedge i_clk);
        end
        wait_idle();
        if (errors == 0 && events_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
